[hdl/playfair_digraph_cipher_macros.svh]
// ----------------------------------------------------------------------------
// Playfair digraph cipher assertion macros
// Shorthand for the concurrent assertions of the cipher checker.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Checked on every rising edge while reset is released.
`define PFC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/pfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher package
// Types, letter codes and small helpers shared by the cipher modules.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SQ_DIM    = 5;
    localparam int CODE_W    = 5;
    localparam int ROW_W     = SQ_DIM * CODE_W;
    localparam int IDX_W     = 3;
    localparam int QPTR_W    = 2;
    localparam int QDEPTH    = 1 << QPTR_W;

    localparam logic [CODE_W-1:0] CODE_I = 5'd8;
    localparam logic [CODE_W-1:0] CODE_J = 5'd9;
    localparam logic [CODE_W-1:0] CODE_X = 5'd23;

    localparam logic [7:0] ASCII_UP_A = 8'd65;
    localparam logic [7:0] ASCII_UP_Z = 8'd90;
    localparam logic [7:0] ASCII_LO_A = 8'd97;
    localparam logic [7:0] ASCII_LO_Z = 8'd122;
    localparam logic [6:0] LETTER_BASE = 7'd65;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_ROW0 = 3'd1;
    localparam logic [2:0] REG_ROW1 = 3'd2;
    localparam logic [2:0] REG_ROW2 = 3'd3;
    localparam logic [2:0] REG_ROW3 = 3'd4;
    localparam logic [2:0] REG_ROW4 = 3'd5;

    localparam logic [ROW_W-1:0] ROW0_RST = 25'd36043;
    localparam logic [ROW_W-1:0] ROW1_RST = 25'd2235792;
    localparam logic [ROW_W-1:0] ROW2_RST = 25'd5518900;
    localparam logic [ROW_W-1:0] ROW3_RST = 25'd10963639;
    localparam logic [ROW_W-1:0] ROW4_RST = 25'd16374553;

    typedef logic [SQ_DIM-1:0][ROW_W-1:0] square_t;

    // One digraph waiting for substitution.
    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic              decrypt;
        logic              last;
    } pair_t;

    // Up to two digraphs handed to the queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        pair_t      e0;
        pair_t      e1;
    } push_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } loc_t;

    // Moves a row or column index one place forward, or back when decrypting.
    function automatic logic [IDX_W-1:0] step5(input logic [IDX_W-1:0] v,
                                               input logic back);
        logic [IDX_W-1:0] res;
        res = '0;
        case (v)
            3'd0: res = back ? 3'd4 : 3'd1;
            3'd1: res = back ? 3'd0 : 3'd2;
            3'd2: res = back ? 3'd1 : 3'd3;
            3'd3: res = back ? 3'd2 : 3'd4;
            3'd4: res = back ? 3'd3 : 3'd0;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

[hdl/playfair_digraph_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Streams text bytes in and Playfair-substituted letters out.
// ----------------------------------------------------------------------------
// A text byte is accepted whenever the digraph queue has two free places;
// each byte yields zero, one or two digraphs. Letters leave one per cycle
// while m_tready is high, and each digraph leaves as its two letters in
// turn. The output port sets the sustained rate. With the pipeline empty, a
// byte's digraph passes these registered steps in order: the acceptance writes
// the queue, then both letters located in the key square are registered, then
// the substituted letters are registered and the first is on the output port.
// The user must write the mode and key square registers through the APB port
// only while the stream is idle; the block does not enforce this. A held
// letter survives a mode change.
module playfair_digraph_cipher import pfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte[7:0]
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_letter[6:0], zero[7]
    output logic        m_tlast    // last_letter
);

    logic        decrypt_mode_reg;
    square_t     square_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    push_t       push;
    logic        q_room, head_valid, pop;
    pair_t       head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_mode_reg <= 1'b0;
            square_reg[0]    <= ROW0_RST;
            square_reg[1]    <= ROW1_RST;
            square_reg[2]    <= ROW2_RST;
            square_reg[3]    <= ROW3_RST;
            square_reg[4]    <= ROW4_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE: decrypt_mode_reg <= pwdata[0];
                REG_ROW0: square_reg[0]    <= pwdata[ROW_W-1:0];
                REG_ROW1: square_reg[1]    <= pwdata[ROW_W-1:0];
                REG_ROW2: square_reg[2]    <= pwdata[ROW_W-1:0];
                REG_ROW3: square_reg[3]    <= pwdata[ROW_W-1:0];
                REG_ROW4: square_reg[4]    <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: prdata = {31'd0, decrypt_mode_reg};
            REG_ROW0: prdata = {7'd0, square_reg[0]};
            REG_ROW1: prdata = {7'd0, square_reg[1]};
            REG_ROW2: prdata = {7'd0, square_reg[2]};
            REG_ROW3: prdata = {7'd0, square_reg[3]};
            REG_ROW4: prdata = {7'd0, square_reg[4]};
            default:  prdata = 32'd0;
        endcase
    end

    pfc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .decrypt_mode (decrypt_mode_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .q_room       (q_room),
        .push         (push)
    );

    pfc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (q_room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    pfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .square     (square_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[hdl/pfc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher front end
// Filters text bytes, folds case and J, and forms digraphs for the queue.
// ----------------------------------------------------------------------------
module pfc_front import pfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        decrypt_mode,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte[7:0]
    input  logic        s_tlast,   // end_of_message
    input  logic        q_room,
    output push_t       push
);

    logic              held_valid_reg, held_valid_next;
    logic [CODE_W-1:0] held_letter_reg, held_letter_next;

    logic              is_upper, is_lower, is_letter, accept;
    logic [7:0]        offset;
    logic [CODE_W-1:0] code;
    logic              p1_valid, p2_valid;
    pair_t             p1, p2;
    logic              mid_valid;
    logic [CODE_W-1:0] mid_letter;

    assign s_tready = q_room;
    assign accept   = s_tvalid && s_tready;

    assign is_upper  = (s_tdata >= ASCII_UP_A) && (s_tdata <= ASCII_UP_Z);
    assign is_lower  = (s_tdata >= ASCII_LO_A) && (s_tdata <= ASCII_LO_Z);
    assign is_letter = is_upper || is_lower;
    assign offset    = is_upper ? (s_tdata - ASCII_UP_A) : (s_tdata - ASCII_LO_A);

    always_comb begin
        code = offset[CODE_W-1:0];
        if (code == CODE_J) begin
            code = CODE_I;
        end
    end

    always_comb begin
        p1_valid   = 1'b0;
        p1         = '0;
        p2_valid   = 1'b0;
        p2         = '0;
        mid_valid  = held_valid_reg;
        mid_letter = held_letter_reg;

        if (is_letter) begin
            if (!held_valid_reg) begin
                mid_valid  = 1'b1;
                mid_letter = code;
            end else if (!decrypt_mode && (held_letter_reg == code)) begin
                // When encrypting, a doubled letter closes the pair with filler and opens the next.
                p1_valid   = 1'b1;
                p1.first   = held_letter_reg;
                p1.second  = CODE_X;
                mid_valid  = 1'b1;
                mid_letter = code;
            end else begin
                p1_valid   = 1'b1;
                p1.first   = held_letter_reg;
                p1.second  = code;
                mid_valid  = 1'b0;
                mid_letter = '0;
            end
        end
        p1.decrypt = decrypt_mode;

        if (s_tlast && mid_valid) begin
            p2_valid   = 1'b1;
            p2.first   = mid_letter;
            p2.second  = CODE_X;
            p2.last    = 1'b1;
            mid_valid  = 1'b0;
            mid_letter = '0;
        end
        p2.decrypt = decrypt_mode;
        p1.last    = s_tlast && !p2_valid;
    end

    always_comb begin
        push.count = '0;
        push.e0    = p1_valid ? p1 : p2;
        push.e1    = p2;
        if (accept) begin
            push.count = {1'b0, p1_valid} + {1'b0, p2_valid};
        end
    end

    always_comb begin
        held_valid_next  = held_valid_reg;
        held_letter_next = held_letter_reg;
        if (accept) begin
            held_valid_next  = mid_valid;
            held_letter_next = mid_letter;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg  <= 1'b0;
            held_letter_reg <= '0;
        end else begin
            held_valid_reg  <= held_valid_next;
            held_letter_reg <= held_letter_next;
        end
    end

endmodule

[hdl/pfc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher digraph queue
// Small FIFO taking up to two digraphs per cycle and giving one.
// ----------------------------------------------------------------------------
module pfc_queue import pfc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  head_valid,
    output pair_t head,
    input  logic  pop
);

    pair_t              mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_plus1;
    logic               do_pop;

    // Room for the largest push of one transaction.
    assign room         = count_reg <= (QPTR_W+1)'(QDEPTH - 2);
    assign head_valid   = count_reg != '0;
    assign head         = mem[rd_ptr_reg];
    assign do_pop       = pop && head_valid;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push.count[QPTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + {{(QPTR_W-1){1'b0}}, do_pop};
        count_next  = count_reg + {{(QPTR_W-1){1'b0}}, push.count}
                      - {{QPTR_W{1'b0}}, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.e0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_plus1] <= push.e1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/pfc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher back end
// Locates a digraph in the key square, substitutes it and sends two letters.
// ----------------------------------------------------------------------------
module pfc_back import pfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  square_t     square,
    input  logic        head_valid,
    input  pair_t       head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_letter[6:0], zero[7]
    output logic        m_tlast    // last_letter
);

    // First match in row-major order; a letter missing from the square sits at 0,0.
    function automatic loc_t locate(input square_t sq, input logic [CODE_W-1:0] code);
        loc_t res;
        res = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--) begin
            for (int c = SQ_DIM - 1; c >= 0; c--) begin
                if (sq[r][CODE_W*c +: CODE_W] == code) begin
                    res.row = IDX_W'(r);
                    res.col = IDX_W'(c);
                end
            end
        end
        return res;
    endfunction

    logic              l_valid_reg, l_valid_next;
    loc_t              l_a_reg, l_b_reg;
    logic              l_decrypt_reg, l_last_reg;

    logic              o_valid_reg, o_valid_next;
    logic              o_phase_reg, o_phase_next;
    logic [6:0]        o_x_reg, o_y_reg;
    logic              o_last_reg;

    logic [CODE_W-1:0] cells [SQ_DIM][SQ_DIM];
    logic              o_load, l_take;
    logic [IDX_W-1:0]  xr, xc, yr, yc;
    logic [CODE_W-1:0] x_code, y_code;

    always_comb begin
        for (int r = 0; r < SQ_DIM; r++) begin
            for (int c = 0; c < SQ_DIM; c++) begin
                cells[r][c] = square[r][CODE_W*c +: CODE_W];
            end
        end
    end

    assign o_load = l_valid_reg && (!o_valid_reg || (m_tready && o_phase_reg));
    assign l_take = !l_valid_reg || o_load;
    assign pop    = l_take;

    always_comb begin
        if (l_a_reg.row == l_b_reg.row) begin
            xr = l_a_reg.row;
            xc = step5(l_a_reg.col, l_decrypt_reg);
            yr = l_b_reg.row;
            yc = step5(l_b_reg.col, l_decrypt_reg);
        end else if (l_a_reg.col == l_b_reg.col) begin
            xr = step5(l_a_reg.row, l_decrypt_reg);
            xc = l_a_reg.col;
            yr = step5(l_b_reg.row, l_decrypt_reg);
            yc = l_b_reg.col;
        end else begin
            xr = l_a_reg.row;
            xc = l_b_reg.col;
            yr = l_b_reg.row;
            yc = l_a_reg.col;
        end
        x_code = cells[xr][xc];
        y_code = cells[yr][yc];
    end

    always_comb begin
        l_valid_next = l_valid_reg;
        if (l_take) begin
            l_valid_next = head_valid;
        end
    end

    always_comb begin
        o_valid_next = o_valid_reg;
        o_phase_next = o_phase_reg;
        if (o_load) begin
            o_valid_next = 1'b1;
            o_phase_next = 1'b0;
        end else if (o_valid_reg && m_tready) begin
            if (o_phase_reg) begin
                o_valid_next = 1'b0;
            end else begin
                o_phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (l_take && head_valid) begin
            l_a_reg       <= locate(square, head.first);
            l_b_reg       <= locate(square, head.second);
            l_decrypt_reg <= head.decrypt;
            l_last_reg    <= head.last;
        end
        if (o_load) begin
            o_x_reg    <= LETTER_BASE + {2'b00, x_code};
            o_y_reg    <= LETTER_BASE + {2'b00, y_code};
            o_last_reg <= l_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            o_phase_reg <= 1'b0;
        end else begin
            l_valid_reg <= l_valid_next;
            o_valid_reg <= o_valid_next;
            o_phase_reg <= o_phase_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {1'b0, (o_phase_reg ? o_y_reg : o_x_reg)};
    assign m_tlast  = o_last_reg && o_phase_reg;

endmodule

[hdl/pfc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher port checker
// Watches the top-level ports of the cipher over time.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_macros.svh"

module pfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // A stalled output transaction keeps its letter and its end mark.
    `PFC_ASSERT(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "output transaction changed while stalled")

    // Letters come from the square, so they lie between A and code 31 above it.
    `PFC_ASSERT(a_letter_range, aclk, aresetn, m_tvalid |-> (m_tdata >= 8'd65 && m_tdata <= 8'd96), "output letter out of range")

    // Reset leaves no result pending.
    `PFC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // The configuration port never inserts wait states.
    `PFC_ASSERT_ALWAYS(a_pready_high, aclk, aresetn |-> pready, "pready dropped")

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);
